// ===== rtl/core/sha_pkg.sv =====
// sha_pkg: shared constants, round table and sigma functions of the sha-256 engine
// used by sha256_stream_hash and sha_checker; no dependencies
`timescale 1ns / 1ps

package sha_pkg;

    localparam int WordWidth  = 32;
    localparam int ChainWords = 8;

    // command codes of the input item
    localparam logic [1:0] CmdAbsorb  = 2'd0;
    localparam logic [1:0] CmdFinish  = 2'd1;
    localparam logic [1:0] CmdRestart = 2'd2;

    // padding marker byte and the fill level of the last byte before the length field starts
    localparam logic [7:0] PadMarker  = 8'h80;
    localparam logic [5:0] LenStartM1 = 6'd55;
    localparam logic [5:0] LastFill   = 6'd63;
    localparam logic [5:0] LastRound  = 6'd63;

    localparam logic [2:0] LastWordIdx = 3'd7;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] val;
        unique case (idx)
            3'd0: val = 32'h6a09e667;
            3'd1: val = 32'hbb67ae85;
            3'd2: val = 32'h3c6ef372;
            3'd3: val = 32'ha54ff53a;
            3'd4: val = 32'h510e527f;
            3'd5: val = 32'h9b05688c;
            3'd6: val = 32'h1f83d9ab;
            3'd7: val = 32'h5be0cd19;
            default: val = 32'h0;
        endcase
        return val;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] val;
        unique case (idx)
            6'd0:  val = 32'h428a2f98;
            6'd1:  val = 32'h71374491;
            6'd2:  val = 32'hb5c0fbcf;
            6'd3:  val = 32'he9b5dba5;
            6'd4:  val = 32'h3956c25b;
            6'd5:  val = 32'h59f111f1;
            6'd6:  val = 32'h923f82a4;
            6'd7:  val = 32'hab1c5ed5;
            6'd8:  val = 32'hd807aa98;
            6'd9:  val = 32'h12835b01;
            6'd10: val = 32'h243185be;
            6'd11: val = 32'h550c7dc3;
            6'd12: val = 32'h72be5d74;
            6'd13: val = 32'h80deb1fe;
            6'd14: val = 32'h9bdc06a7;
            6'd15: val = 32'hc19bf174;
            6'd16: val = 32'he49b69c1;
            6'd17: val = 32'hefbe4786;
            6'd18: val = 32'h0fc19dc6;
            6'd19: val = 32'h240ca1cc;
            6'd20: val = 32'h2de92c6f;
            6'd21: val = 32'h4a7484aa;
            6'd22: val = 32'h5cb0a9dc;
            6'd23: val = 32'h76f988da;
            6'd24: val = 32'h983e5152;
            6'd25: val = 32'ha831c66d;
            6'd26: val = 32'hb00327c8;
            6'd27: val = 32'hbf597fc7;
            6'd28: val = 32'hc6e00bf3;
            6'd29: val = 32'hd5a79147;
            6'd30: val = 32'h06ca6351;
            6'd31: val = 32'h14292967;
            6'd32: val = 32'h27b70a85;
            6'd33: val = 32'h2e1b2138;
            6'd34: val = 32'h4d2c6dfc;
            6'd35: val = 32'h53380d13;
            6'd36: val = 32'h650a7354;
            6'd37: val = 32'h766a0abb;
            6'd38: val = 32'h81c2c92e;
            6'd39: val = 32'h92722c85;
            6'd40: val = 32'ha2bfe8a1;
            6'd41: val = 32'ha81a664b;
            6'd42: val = 32'hc24b8b70;
            6'd43: val = 32'hc76c51a3;
            6'd44: val = 32'hd192e819;
            6'd45: val = 32'hd6990624;
            6'd46: val = 32'hf40e3585;
            6'd47: val = 32'h106aa070;
            6'd48: val = 32'h19a4c116;
            6'd49: val = 32'h1e376c08;
            6'd50: val = 32'h2748774c;
            6'd51: val = 32'h34b0bcb5;
            6'd52: val = 32'h391c0cb3;
            6'd53: val = 32'h4ed8aa4a;
            6'd54: val = 32'h5b9cca4f;
            6'd55: val = 32'h682e6ff3;
            6'd56: val = 32'h748f82ee;
            6'd57: val = 32'h78a5636f;
            6'd58: val = 32'h84c87814;
            6'd59: val = 32'h8cc70208;
            6'd60: val = 32'h90befffa;
            6'd61: val = 32'ha4506ceb;
            6'd62: val = 32'hbef9a3f7;
            6'd63: val = 32'hc67178f2;
            default: val = 32'h0;
        endcase
        return val;
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/core/sha256_stream_hash.sv =====
// sha256_stream_hash: byte-serial sha-256 engine with one shared round unit
// depends on sha_pkg (round table, initial hash, sigma functions, command codes)
// an absorbed byte is taken while idle; the byte that fills a block starts 64 rounds and then the chain add
// finish: pad bytes to the block end, a second block when the fill is past 55; 8 words, 1 per cycle unless stalled
// a single round unit does 1 round per cycle; the input stalls in every state but idle
// reset: async active low, chain words load the initial hash, counts and flags clear
`timescale 1ns / 1ps

module sha256_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    // digest word channel
    output logic        dig_valid,
    input  logic        dig_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // padding phases
    localparam logic [2:0] P_NONE = 3'd0;
    localparam logic [2:0] P_MARK = 3'd1;
    localparam logic [2:0] P_ZERO = 3'd2;
    localparam logic [2:0] P_LEN  = 3'd3;
    localparam logic [2:0] P_DONE = 3'd4;

    // control state
    logic [2:0]  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] bytes_reg, bytes_next;
    logic        fin_reg, fin_next;
    logic [2:0]  len_cnt_reg, len_cnt_next;
    logic [2:0]  emit_cnt_reg, emit_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] h_reg [sha_pkg::ChainWords];
    logic [31:0] h_next [sha_pkg::ChainWords];

    // payload state
    // block window: byte shift line while absorbing, 16-word schedule window during rounds
    logic [511:0] blk_reg, blk_next;
    logic [31:0]  v_reg [sha_pkg::ChainWords];
    logic [31:0]  v_next [sha_pkg::ChainWords];
    logic [31:0]  word_reg, word_next;
    logic [2:0]   idx_reg, idx_next;
    logic         last_reg, last_next;

    // round unit signals
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] ch_val;
    logic [31:0] maj_val;
    logic [31:0] t1;
    logic [31:0] t2;

    // byte push path shared by absorb and padding
    logic        push_en;
    logic [7:0]  push_byte;
    logic [63:0] bit_len;
    logic [5:0]  len_sh;
    logic [7:0]  len_byte;
    logic        out_free;

    assign cmd_stall   = (state_reg != S_IDLE);
    assign dig_valid   = out_valid_reg;
    assign digest_word = word_reg;
    assign word_index  = idx_reg;
    assign last_word   = last_reg;

    assign out_free = !out_valid_reg || !dig_stall;

    // message length in bits, sent most significant byte first
    assign bit_len  = {bytes_reg, 3'b000};
    assign len_sh   = {~len_cnt_reg, 3'b000};
    assign len_byte = bit_len[len_sh +: 8];

    // schedule: window word 0 is w[t], the new word is w[t+16]
    assign w_cur = blk_reg[511:480];
    assign w_new = sha_pkg::small_sigma1(blk_reg[63:32]) + blk_reg[223:192]
                 + sha_pkg::small_sigma0(blk_reg[479:448]) + blk_reg[511:480];

    // one compression round
    assign ch_val  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj_val = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1 = v_reg[7] + sha_pkg::big_sigma1(v_reg[4]) + ch_val
              + sha_pkg::round_k(rnd_reg) + w_cur;
    assign t2 = sha_pkg::big_sigma0(v_reg[0]) + maj_val;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        rnd_next       = rnd_reg;
        fill_next      = fill_reg;
        bytes_next     = bytes_reg;
        fin_next       = fin_reg;
        len_cnt_next   = len_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = out_valid_reg && dig_stall;
        h_next         = h_reg;
        blk_next       = blk_reg;
        v_next         = v_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        push_en        = 1'b0;
        push_byte      = 8'h00;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (command)
                        sha_pkg::CmdAbsorb:
                        begin
                            // bytes after finish are dropped
                            if (!fin_reg)
                            begin
                                push_en    = 1'b1;
                                push_byte  = data_byte;
                                bytes_next = bytes_reg + 61'd1;
                            end
                        end
                        sha_pkg::CmdFinish:
                        begin
                            if (fin_reg)
                            begin
                                // digest already final, send it again
                                state_next    = S_EMIT;
                                emit_cnt_next = 3'd0;
                            end
                            else
                            begin
                                state_next   = S_PAD;
                                phase_next   = P_MARK;
                                len_cnt_next = 3'd0;
                                fin_next     = 1'b1;
                            end
                        end
                        sha_pkg::CmdRestart:
                        begin
                            for (int i = 0; i < sha_pkg::ChainWords; i++)
                            begin
                                h_next[i] = sha_pkg::init_hash(3'(i));
                            end
                            fill_next  = 6'd0;
                            bytes_next = 61'd0;
                            fin_next   = 1'b0;
                        end
                        default:
                        begin
                            // unused command code, no effect
                        end
                    endcase
                end
            end

            S_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                blk_next  = {blk_reg[479:0], w_new};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == sha_pkg::LastRound)
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                for (int i = 0; i < sha_pkg::ChainWords; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                if (phase_reg == P_DONE)
                begin
                    state_next    = S_EMIT;
                    phase_next    = P_NONE;
                    emit_cnt_next = 3'd0;
                end
                else if (phase_reg == P_NONE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end

            S_PAD:
            begin
                push_en = 1'b1;
                unique case (phase_reg)
                    P_MARK:
                    begin
                        push_byte  = sha_pkg::PadMarker;
                        phase_next = (fill_reg == sha_pkg::LenStartM1) ? P_LEN : P_ZERO;
                    end
                    P_ZERO:
                    begin
                        push_byte  = 8'h00;
                        phase_next = (fill_reg == sha_pkg::LenStartM1) ? P_LEN : P_ZERO;
                    end
                    P_LEN:
                    begin
                        push_byte    = len_byte;
                        len_cnt_next = len_cnt_reg + 3'd1;
                        if (len_cnt_reg == 3'd7)
                        begin
                            phase_next = P_DONE;
                        end
                    end
                    default:
                    begin
                        push_byte = 8'h00;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    word_next      = h_reg[emit_cnt_reg];
                    idx_next       = emit_cnt_reg;
                    last_next      = (emit_cnt_reg == sha_pkg::LastWordIdx);
                    if (emit_cnt_reg == sha_pkg::LastWordIdx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_cnt_next = emit_cnt_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a byte into the block; the 64th starts the compression
        if (push_en)
        begin
            blk_next  = {blk_reg[503:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == sha_pkg::LastFill)
            begin
                state_next = S_ROUND;
                rnd_next   = 6'd0;
                v_next     = h_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_NONE;
            rnd_reg       <= 6'd0;
            fill_reg      <= 6'd0;
            bytes_reg     <= 61'd0;
            fin_reg       <= 1'b0;
            len_cnt_reg   <= 3'd0;
            emit_cnt_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sha_pkg::ChainWords; i++)
            begin
                h_reg[i] <= sha_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            rnd_reg       <= rnd_next;
            fill_reg      <= fill_next;
            bytes_reg     <= bytes_next;
            fin_reg       <= fin_next;
            len_cnt_reg   <= len_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        v_reg    <= v_next;
        word_reg <= word_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/core/sha_checker.sv =====
// sha_checker: port-level assertions for sha256_stream_hash, bound into every instance of it
// depends on sha_pkg (last word index)
`timescale 1ns / 1ps

module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_stall,
    input logic        dig_valid,
    input logic        dig_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // last flag marks exactly the final word of a digest
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (last_word == (word_index == sha_pkg::LastWordIdx)))
        else $error("last_word does not match word_index");

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_stall |=> dig_valid && $stable(digest_word) && $stable(word_index))
        else $error("stalled digest word changed");

    // words of one digest follow back to back in index order
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_stall && !last_word
        |=> dig_valid && (word_index == $past(word_index) + 3'd1))
        else $error("digest word sequence broken");

    // no new item is taken while a digest is still being sent
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !last_word |-> cmd_stall)
        else $error("item accepted in the middle of a digest");

endmodule

bind sha256_stream_hash sha_checker u_sha_checker (.*);

// ===== sim/sha_checker.sv =====
// sha_digest_checker: watches both channels of sha256_stream_hash, predicts the digest words
// and compares them field by field; depends on sha_pkg for the command codes
`timescale 1ns / 1ps

module sha_digest_checker
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        dig_valid,
    input  logic        dig_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          words_pending
);

    typedef struct {
        logic [31:0] word;
        logic [2:0]  slot;
        logic        is_last;
    } digest_slot_t;

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]  hash_chain [8];
    logic [7:0]   msg_block [64];
    int           block_fill;
    logic [60:0]  msg_byte_count;
    logic         digest_done;
    digest_slot_t expected_words [$];
    int           mismatches;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] digest mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic start_hash();
        for (int i = 0; i < 8; i++)
        begin
            hash_chain[i] = StartHash[i];
        end
        block_fill     = 0;
        msg_byte_count = '0;
        digest_done    = 1'b0;
    endtask

    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] v [8];
        logic [31:0] x, y, t1, t2;
        for (int i = 0; i < 16; i++)
        begin
            sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            x = sched[i-15];
            y = sched[i-2];
            sched[i] = sched[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + sched[i-7]
                     + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_chain[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + sched[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_chain[i] = hash_chain[i] + v[i];
        end
    endtask

    // marker byte, zero fill, 64-bit big-endian bit length; spills into a second block past 55
    task automatic close_message();
        logic [63:0] bit_len;
        bit_len = {msg_byte_count, 3'b000};
        msg_block[block_fill] = 8'h80;
        block_fill++;
        if (block_fill > 56)
        begin
            while (block_fill < 64)
            begin
                msg_block[block_fill] = 8'h00;
                block_fill++;
            end
            compress_block();
            block_fill = 0;
        end
        while (block_fill < 56)
        begin
            msg_block[block_fill] = 8'h00;
            block_fill++;
        end
        for (int i = 0; i < 8; i++)
        begin
            msg_block[56+i] = bit_len[63-8*i -: 8];
        end
        compress_block();
        block_fill  = 0;
        digest_done = 1'b1;
    endtask

    task automatic take_item(input logic [1:0] op, input logic [7:0] value);
        digest_slot_t item;
        case (op)
            CmdAbsorb:
            begin
                if (!digest_done)
                begin
                    msg_block[block_fill] = value;
                    block_fill++;
                    msg_byte_count++;
                    if (block_fill == 64)
                    begin
                        compress_block();
                        block_fill = 0;
                    end
                end
            end
            CmdFinish:
            begin
                if (!digest_done)
                begin
                    close_message();
                end
                for (int i = 0; i < 8; i++)
                begin
                    item.word    = hash_chain[i];
                    item.slot    = 3'(i);
                    item.is_last = (i == 7);
                    expected_words.push_back(item);
                end
            end
            CmdRestart:
            begin
                start_hash();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_word();
        digest_slot_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h at index %0d", digest_word, word_index));
        end
        else
        begin
            want = expected_words.pop_front();
            if (digest_word !== want.word)
            begin
                report_mismatch($sformatf("word %0d: got %h, expected %h",
                                          want.slot, digest_word, want.word));
            end
            if (word_index !== want.slot)
            begin
                report_mismatch($sformatf("word_index: got %0d, expected %0d",
                                          word_index, want.slot));
            end
            if (last_word !== want.is_last)
            begin
                report_mismatch($sformatf("last_word on word %0d: got %b, expected %b",
                                          want.slot, last_word, want.is_last));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hash();
            expected_words.delete();
            mismatches     = 0;
            fail_count    <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                take_item(command, data_byte);
            end
            if (dig_valid && !dig_stall)
            begin
                check_word();
            end
            fail_count    <= mismatches;
            words_pending <= expected_words.size();
        end
    end

endmodule

// ===== sim/sha256_stream_hash_tb.sv =====
// sha256_stream_hash_tb: drives message bytes, finish and restart items into the engine
// and gives the verdict; depends on sha_pkg, sha256_stream_hash and sha_digest_checker
`timescale 1ns / 1ps

module sha256_stream_hash_tb;

    import sha_pkg::*;

    // the one command code the engine must ignore
    localparam logic [1:0] CmdUnused = 2'd3;

    // no item on either channel for this long means the engine is hung
    localparam int WatchdogLimit = 4000;
    // receiver hold-off long enough to back the engine up into the input channel
    localparam int HoldCycles    = 500;
    // quiet time after the last digest word: two-block padding plus margin
    localparam int DrainCycles   = 300;
    localparam int RandomItems   = 150;
    // one full block plus 56 bytes: absorb-side compression and two-block padding
    localparam int SpanLen       = 120;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        dig_valid;
    logic        dig_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int fail_count;
    int words_pending;
    int words_taken = 0;
    int idle_cycles = 0;

    // sender burst state
    int burst_left = 0;
    int random_items = 0;

    // message shape bookkeeping for the random part
    bit msg_open = 1'b0;
    int open_len = 0;
    bit two_block_seen = 1'b0;
    bit full_block_seen = 1'b0;

    bit pressure_done = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sha256_stream_hash uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .data_byte   (data_byte),
        .dig_valid   (dig_valid),
        .dig_stall   (dig_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    sha_digest_checker digest_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .command       (command),
        .data_byte     (data_byte),
        .dig_valid     (dig_valid),
        .dig_stall     (dig_stall),
        .digest_word   (digest_word),
        .word_index    (word_index),
        .last_word     (last_word),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // count digest words taken, the receiver uses it to time its long hold-off
    always @(posedge clk)
    begin
        if (dig_valid && !dig_stall)
        begin
            words_taken <= words_taken + 1;
        end
    end

    // watchdog: any item moving on either channel resets the count
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (dig_valid && !dig_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WatchdogLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // one item on the input channel; a new burst may open with a gap of idle cycles.
    // payload changes at the falling edge, acceptance is judged at the rising edge
    task automatic send_item(input logic [1:0] op, input logic [7:0] value);
        int pause;
        if (burst_left == 0)
        begin
            // a quarter of the bursts follow the previous one back to back
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (pause > 0)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                repeat (pause - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        cmd_valid <= 1'b1;
        command   <= op;
        data_byte <= value;
        do
        begin
            @(posedge clk);
        end
        while (cmd_stall);
    endtask

    // items that reach the hash state count toward the random item budget
    task automatic send_counted(input logic [1:0] op, input logic [7:0] value);
        send_item(op, value);
        random_items++;
    endtask

    // one random message: mostly well formed (restart, bytes, finish),
    // sometimes abandoned, continued, finished twice or followed by stray bytes
    task automatic random_message();
        int len;
        int fill;
        int boundary [4] = '{55, 56, 63, 64};
        if (!two_block_seen || !full_block_seen)
        begin
            // a long message first covers both block cases in one go
            len = SpanLen;
        end
        // a quarter of the messages sit on a padding or block boundary
        else if ($urandom_range(0, 3) == 0)
        begin
            len = boundary[$urandom_range(0, 3)];
        end
        else
        begin
            len = $urandom_range(0, 20);
        end
        // an abandoned message may simply be continued instead of restarted
        if (!msg_open || $urandom_range(0, 2) != 0)
        begin
            send_counted(CmdRestart, 8'($urandom));
            msg_open = 1'b1;
            open_len = 0;
        end
        for (int i = 0; i < len; i++)
        begin
            // unused command code sprinkled among the bytes
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(CmdUnused, 8'($urandom));
            end
            send_counted(CmdAbsorb, 8'($urandom));
            open_len++;
        end
        // broken sequence: no finish, the next restart drops it
        if ($urandom_range(0, 9) == 0)
        begin
            return;
        end
        fill = open_len % 64;
        if (fill >= 56)
        begin
            two_block_seen = 1'b1;
        end
        if (open_len >= 64)
        begin
            full_block_seen = 1'b1;
        end
        send_counted(CmdFinish, 8'($urandom));
        msg_open = 1'b0;
        // repeated finish re-emits the same digest
        if ($urandom_range(0, 4) == 0)
        begin
            send_counted(CmdFinish, 8'($urandom));
        end
        // bytes after finish are dropped by the engine
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3)) send_item(CmdAbsorb, 8'($urandom));
        end
    endtask

    // receiver: runs of no stall, random stall and mostly stall, plus one
    // long hold-off once some digests have gone by
    initial
    begin
        int mode;
        int span;
        dig_stall = 1'b0;
        forever
        begin
            if (!pressure_done && words_taken >= 20)
            begin
                @(negedge clk);
                dig_stall <= 1'b1;
                repeat (HoldCycles) @(negedge clk);
                pressure_done = 1'b1;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 40);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       dig_stall <= 1'b0;
                    1:       dig_stall <= 1'($urandom_range(0, 1));
                    default: dig_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        command   = CmdAbsorb;
        data_byte = 8'h00;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // empty message straight after reset, then finish again for the same digest
        send_item(CmdFinish, 8'hff);
        send_item(CmdFinish, 8'h00);
        // byte after finish is ignored, as is the unused command
        send_item(CmdAbsorb, 8'hff);
        send_item(CmdUnused, 8'hff);
        // data extremes, with the unused command in the middle of a message
        send_item(CmdRestart, 8'hff);
        send_item(CmdAbsorb, 8'h00);
        send_item(CmdAbsorb, 8'hff);
        send_item(CmdAbsorb, 8'ha5);
        send_item(CmdUnused, 8'h00);
        send_item(CmdAbsorb, 8'h5a);
        send_item(CmdFinish, 8'h00);
        // the classic three-letter message
        send_item(CmdRestart, 8'h00);
        send_item(CmdAbsorb, 8'h61);
        send_item(CmdAbsorb, 8'h62);
        send_item(CmdAbsorb, 8'h63);
        send_item(CmdFinish, 8'h00);
        // restart in the middle of a message throws the byte away
        send_item(CmdRestart, 8'h00);
        send_item(CmdAbsorb, 8'h01);
        send_item(CmdRestart, 8'h00);
        send_item(CmdFinish, 8'h00);

        // random messages until the budget is spent and both the two-block
        // padding and the absorb-side block compression have been hit
        while (random_items < RandomItems || !two_block_seen || !full_block_seen)
        begin
            random_message();
        end

        @(negedge clk);
        cmd_valid <= 1'b0;

        // wait for the last digest word; the watchdog covers a hang
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sha_pkg.sv
rtl/core/sha256_stream_hash.sv
rtl/core/sha_checker.sv
sim/sha_checker.sv
sim/sha256_stream_hash_tb.sv
